// File: hw/rtl/lci_pkg.sv
// ----------------------------------------------------------------------------
// Line and circle crossing package
// Widths, result codes and the sideband record shared by the pipeline parts.
// ----------------------------------------------------------------------------
package lci_pkg;

   localparam int WORD_BITS  = 32;
   localparam int RAD_BITS   = WORD_BITS - 1;
   localparam int DIFF_BITS  = WORD_BITS + 1;
   localparam int L2_BITS    = 2 * WORD_BITS + 1;
   localparam int P_BITS     = 2 * WORD_BITS + 2;
   localparam int ROOT_BITS  = 2 * WORD_BITS;
   localparam int RAD_BITS_D = 4 * WORD_BITS;
   localparam int QUOT_BITS  = 2 * WORD_BITS + 2;
   localparam int NUM_BITS   = 3 * WORD_BITS + 2;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_TANGENT  = 2'd1,
      STATUS_TWO      = 2'd2,
      STATUS_VERTICAL = 2'd3
   } status_type;

   typedef struct packed {
      logic                        vert;
      logic                        d_neg;
      logic                        d_zero;
      logic signed [WORD_BITS-1:0] x1;
      logic [L2_BITS-1:0]          l2;
      logic signed [P_BITS-1:0]    p;
      logic                        dx_neg;
      logic [WORD_BITS-1:0]        dx_mag;
   } side_type;

endpackage

// File: hw/rtl/lci_if.sv
// ----------------------------------------------------------------------------
// Line and circle crossing channels
// Request and response channels with valid, ready and the word payload.
// ----------------------------------------------------------------------------
interface lci_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lci_pkg::WORD_BITS-1:0] line_start_x;
   logic signed [lci_pkg::WORD_BITS-1:0] line_start_y;
   logic signed [lci_pkg::WORD_BITS-1:0] line_end_x;
   logic signed [lci_pkg::WORD_BITS-1:0] line_end_y;
   logic signed [lci_pkg::WORD_BITS-1:0] centre_x;
   logic signed [lci_pkg::WORD_BITS-1:0] centre_y;
   logic [lci_pkg::RAD_BITS-1:0]         radius;

   modport source (output valid, line_start_x, line_start_y, line_end_x, line_end_y,
                   centre_x, centre_y, radius, input ready);
   modport sink (input valid, line_start_x, line_start_y, line_end_x, line_end_y,
                 centre_x, centre_y, radius, output ready);
endinterface

interface lci_rsp_if;
   logic                                 valid;
   logic                                 ready;
   lci_pkg::status_type                  status;
   logic signed [lci_pkg::WORD_BITS-1:0] first_x;
   logic signed [lci_pkg::WORD_BITS-1:0] second_x;

   modport source (output valid, status, first_x, second_x, input ready);
   modport sink (input valid, status, first_x, second_x, output ready);
endinterface

// File: hw/rtl/line_circle_intersect.sv
// ----------------------------------------------------------------------------
// Line and circle crossing
// Crossing x coordinates of a line through two points with a circle.
// ----------------------------------------------------------------------------
// The block takes one request word per clock while the response side keeps up
// and returns one response word for each, in order. The pipeline has eight
// stages for the quadratic terms and discriminant, 65 for the bit-serial square
// root, 72 for the two floor divisions and saturation, and the output register.
// The whole pipeline holds while a finished word waits at the output and
// another one reaches the end.
module line_circle_intersect (
   input  logic      clock,
   input  logic      reset,
   lci_req_if.sink   req_chan,
   lci_rsp_if.source rsp_chan
);

   localparam int W = lci_pkg::WORD_BITS;

   logic adv;
   logic fr_valid, sq_valid, dv_valid;
   lci_pkg::side_type fr_side, sq_side, dv_side;
   logic [lci_pkg::RAD_BITS_D-1:0] fr_d;
   logic [lci_pkg::ROOT_BITS-1:0]  sq_s;
   logic signed [W-1:0] xa, xb;

   logic                rsp_valid_ff;
   lci_pkg::status_type status_ff, status_in;
   logic signed [W-1:0] first_ff, first_in, second_ff, second_in;
   logic                take;

   assign take         = !rsp_valid_ff || rsp_chan.ready;
   assign adv          = !dv_valid || take;
   assign req_chan.ready = adv && !reset;

   lci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_chan.valid),
      .x1        (req_chan.line_start_x),
      .y1        (req_chan.line_start_y),
      .x2        (req_chan.line_end_x),
      .y2        (req_chan.line_end_y),
      .cx        (req_chan.centre_x),
      .cy        (req_chan.centre_y),
      .r         (req_chan.radius),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_d     (fr_d)
   );

   lci_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_d      (fr_d),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_s     (sq_s)
   );

   lci_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_side   (sq_side),
      .in_s      (sq_s),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_xa    (xa),
      .out_xb    (xb)
   );

   always_comb begin
      status_in = lci_pkg::STATUS_TWO;
      first_in  = '0;
      second_in = '0;
      priority if (dv_side.vert) begin
         status_in = lci_pkg::STATUS_VERTICAL;
      end else if (dv_side.d_neg) begin
         status_in = lci_pkg::STATUS_NONE;
      end else if (dv_side.d_zero) begin
         status_in = lci_pkg::STATUS_TANGENT;
         first_in  = xa;
      end else if (xb < xa) begin
         first_in  = xb;
         second_in = xa;
      end else begin
         first_in  = xa;
         second_in = xb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= dv_valid;
      end
      if (take && dv_valid) begin
         status_ff <= status_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = status_ff;
   assign rsp_chan.first_x  = first_ff;
   assign rsp_chan.second_x = second_ff;

endmodule

// File: hw/rtl/lci_front.sv
// ----------------------------------------------------------------------------
// Line and circle crossing front end
// Differences, products, quadratic terms and the discriminant, eight stages.
// ----------------------------------------------------------------------------
module lci_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  logic signed [lci_pkg::WORD_BITS-1:0] x1,
   input  logic signed [lci_pkg::WORD_BITS-1:0] y1,
   input  logic signed [lci_pkg::WORD_BITS-1:0] x2,
   input  logic signed [lci_pkg::WORD_BITS-1:0] y2,
   input  logic signed [lci_pkg::WORD_BITS-1:0] cx,
   input  logic signed [lci_pkg::WORD_BITS-1:0] cy,
   input  logic [lci_pkg::RAD_BITS-1:0]         r,
   output logic                                 out_valid,
   output lci_pkg::side_type                    out_side,
   output logic [lci_pkg::RAD_BITS_D-1:0]       out_d
);

   localparam int W  = lci_pkg::WORD_BITS;
   localparam int DW = lci_pkg::DIFF_BITS;
   localparam int RW = lci_pkg::RAD_BITS;
   localparam int LW = lci_pkg::L2_BITS;
   localparam int PW = lci_pkg::P_BITS;
   localparam int RRW = 2 * RW;
   localparam int RLW = RRW + LW;
   localparam int KW  = LW;
   localparam int KSW = 2 * KW;
   localparam int DDW = KSW + 1;
   localparam int HL  = W;

   logic [7:0] vld_ff;

   logic signed [W-1:0] x1_0_ff, y1_0_ff, x2_0_ff, y2_0_ff, cx_0_ff, cy_0_ff;
   logic [RW-1:0]       r0_ff;

   logic signed [DW-1:0] dx1_ff, dy1_ff, u1_ff, v1_ff;
   logic signed [DW-1:0] dx1_in, dy1_in, u1_in, v1_in;
   logic [RW-1:0]        r1_ff;
   logic signed [W-1:0]  x1_1_ff;

   logic signed [2*DW-1:0] dxx_full, dyy_full, udx_full, vdy_full, udy_full, vdx_full;
   logic [DW-1:0]          dx_abs;
   logic [2*W-1:0]         dxx2_ff, dyy2_ff;
   logic signed [2*W:0]    udx2_ff, vdy2_ff, udy2_ff, vdx2_ff;
   logic [RRW-1:0]         rr2_ff, rr2_in;
   logic signed [W-1:0]    x1_2_ff;
   logic                   dxneg2_ff, vert2_ff;
   logic [W-1:0]           dxmag2_ff;

   lci_pkg::side_type   side3_ff, side3_in;
   logic signed [PW-1:0] k3_ff, k3_in;
   logic [RRW-1:0]       rr3_ff;

   logic [PW-1:0]      k_abs;
   logic [RW-1:0]      rr_lo, rr_hi;
   logic [HL-1:0]      l2_lo;
   logic [LW-HL-1:0]   l2_hi;
   lci_pkg::side_type  side4_ff;
   logic [KW-1:0]      kmag4_ff;
   logic [RW+HL-1:0]   a00_ff, a00_in, a10_ff, a10_in;
   logic [RW+LW-HL-1:0] a01_ff, a01_in, a11_ff, a11_in;

   logic [HL-1:0]       k_lo;
   logic [KW-HL-1:0]    k_hi;
   lci_pkg::side_type   side5_ff;
   logic [RLW-1:0]      rl5_ff, rl5_in;
   logic [2*HL-1:0]     k00_ff, k00_in;
   logic [KW-1:0]       k01_ff, k01_in;
   logic [2*(KW-HL)-1:0] k11_ff, k11_in;

   lci_pkg::side_type side6_ff;
   logic [RLW-1:0]    rl6_ff;
   logic [KSW-1:0]    ks6_ff, ks6_in;

   lci_pkg::side_type   side7_ff;
   logic signed [DDW-1:0] d7_ff, d7_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[6:0], in_valid};
      end
   end

   assign dx1_in = DW'(x2_0_ff) - DW'(x1_0_ff);
   assign dy1_in = DW'(y2_0_ff) - DW'(y1_0_ff);
   assign u1_in  = DW'(x1_0_ff) - DW'(cx_0_ff);
   assign v1_in  = DW'(y1_0_ff) - DW'(cy_0_ff);

   assign dxx_full = dx1_ff * dx1_ff;
   assign dyy_full = dy1_ff * dy1_ff;
   assign udx_full = u1_ff * dx1_ff;
   assign vdy_full = v1_ff * dy1_ff;
   assign udy_full = u1_ff * dy1_ff;
   assign vdx_full = v1_ff * dx1_ff;
   assign rr2_in   = r1_ff * r1_ff;
   assign dx_abs   = dx1_ff[DW-1] ? (DW'(0) - dx1_ff) : dx1_ff;

   always_comb begin
      side3_in        = '0;
      side3_in.vert   = vert2_ff;
      side3_in.x1     = x1_2_ff;
      side3_in.l2     = LW'(dxx2_ff) + LW'(dyy2_ff);
      side3_in.p      = PW'(udx2_ff) + PW'(vdy2_ff);
      side3_in.dx_neg = dxneg2_ff;
      side3_in.dx_mag = dxmag2_ff;
   end
   assign k3_in = PW'(udy2_ff) - PW'(vdx2_ff);

   assign k_abs  = k3_ff[PW-1] ? (PW'(0) - k3_ff) : k3_ff;
   assign rr_lo  = rr3_ff[RW-1:0];
   assign rr_hi  = rr3_ff[RRW-1:RW];
   assign l2_lo  = side3_ff.l2[HL-1:0];
   assign l2_hi  = side3_ff.l2[LW-1:HL];
   assign a00_in = rr_lo * l2_lo;
   assign a01_in = rr_lo * l2_hi;
   assign a10_in = rr_hi * l2_lo;
   assign a11_in = rr_hi * l2_hi;

   assign k_lo   = kmag4_ff[HL-1:0];
   assign k_hi   = kmag4_ff[KW-1:HL];
   assign k00_in = k_lo * k_lo;
   assign k01_in = k_lo * k_hi;
   assign k11_in = k_hi * k_hi;
   assign rl5_in = RLW'(a00_ff) + (RLW'(a01_ff) << HL) + (RLW'(a10_ff) << RW)
                 + (RLW'(a11_ff) << (RW + HL));

   assign ks6_in = KSW'(k00_ff) + (KSW'(k01_ff) << (HL + 1)) + (KSW'(k11_ff) << (2 * HL));

   assign d7_in = $signed(DDW'(rl6_ff)) - $signed(DDW'(ks6_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_0_ff  <= x1;
         y1_0_ff  <= y1;
         x2_0_ff  <= x2;
         y2_0_ff  <= y2;
         cx_0_ff  <= cx;
         cy_0_ff  <= cy;
         r0_ff    <= r;

         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         u1_ff    <= u1_in;
         v1_ff    <= v1_in;
         r1_ff    <= r0_ff;
         x1_1_ff  <= x1_0_ff;

         dxx2_ff   <= dxx_full[2*W-1:0];
         dyy2_ff   <= dyy_full[2*W-1:0];
         udx2_ff   <= udx_full[2*W:0];
         vdy2_ff   <= vdy_full[2*W:0];
         udy2_ff   <= udy_full[2*W:0];
         vdx2_ff   <= vdx_full[2*W:0];
         rr2_ff    <= rr2_in;
         x1_2_ff   <= x1_1_ff;
         dxneg2_ff <= dx1_ff[DW-1];
         dxmag2_ff <= dx_abs[W-1:0];
         vert2_ff  <= (dx1_ff == '0);

         side3_ff <= side3_in;
         k3_ff    <= k3_in;
         rr3_ff   <= rr2_ff;

         side4_ff <= side3_ff;
         kmag4_ff <= k_abs[KW-1:0];
         a00_ff   <= a00_in;
         a01_ff   <= a01_in;
         a10_ff   <= a10_in;
         a11_ff   <= a11_in;

         side5_ff <= side4_ff;
         rl5_ff   <= rl5_in;
         k00_ff   <= k00_in;
         k01_ff   <= k01_in;
         k11_ff   <= k11_in;

         side6_ff <= side5_ff;
         rl6_ff   <= rl5_ff;
         ks6_ff   <= ks6_in;

         side7_ff <= side6_ff;
         d7_ff    <= d7_in;
      end
   end

   always_comb begin
      out_side        = side7_ff;
      out_side.d_neg  = d7_ff[DDW-1];
      out_side.d_zero = (d7_ff == '0);
      out_d           = d7_ff[DDW-1] ? '0 : d7_ff[lci_pkg::RAD_BITS_D-1:0];
   end

   assign out_valid = vld_ff[7];

endmodule

// File: hw/rtl/lci_sqrt.sv
// ----------------------------------------------------------------------------
// Line and circle crossing square root
// Floor square root of the discriminant, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module lci_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  lci_pkg::side_type                  in_side,
   input  logic [lci_pkg::RAD_BITS_D-1:0]     in_d,
   output logic                               out_valid,
   output lci_pkg::side_type                  out_side,
   output logic [lci_pkg::ROOT_BITS-1:0]      out_s
);

   localparam int SB = lci_pkg::ROOT_BITS;
   localparam int RB = lci_pkg::RAD_BITS_D + 1;

   logic [SB:0]       vld_ff;
   logic [RB-1:0]     rem_ff  [0:SB];
   logic [SB-1:0]     root_ff [0:SB];
   lci_pkg::side_type side_ff [0:SB];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[SB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= RB'(in_d);
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < SB; k++) begin : g_step
      localparam int B = SB - 1 - k;
      logic [RB-1:0] trial;
      logic          fits;

      assign trial = (RB'(root_ff[k]) << (B + 1)) | (RB'(1) << (2 * B));
      assign fits  = (rem_ff[k] >= trial);

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1]  <= fits ? (rem_ff[k] - trial) : rem_ff[k];
            root_ff[k+1] <= fits ? (root_ff[k] | (SB'(1) << B)) : root_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[SB];
   assign out_side  = side_ff[SB];
   assign out_s     = root_ff[SB];

endmodule

// File: hw/rtl/lci_div.sv
// ----------------------------------------------------------------------------
// Line and circle crossing root division
// Both root numerators, floor division by the squared length, saturation.
// ----------------------------------------------------------------------------
module lci_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  lci_pkg::side_type                    in_side,
   input  logic [lci_pkg::ROOT_BITS-1:0]        in_s,
   output logic                                 out_valid,
   output lci_pkg::side_type                    out_side,
   output logic signed [lci_pkg::WORD_BITS-1:0] out_xa,
   output logic signed [lci_pkg::WORD_BITS-1:0] out_xb
);

   localparam int W   = lci_pkg::WORD_BITS;
   localparam int SB  = lci_pkg::ROOT_BITS;
   localparam int LW  = lci_pkg::L2_BITS;
   localparam int PW  = lci_pkg::P_BITS;
   localparam int TW  = PW + 1;
   localparam int MW  = PW;
   localparam int QB  = lci_pkg::QUOT_BITS;
   localparam int NB  = lci_pkg::NUM_BITS;
   localparam int HM  = MW / 2;
   localparam int PPW = W + HM;
   localparam int QSW = QB + 2;
   localparam int SUW = QSW + 1;
   localparam int ND  = QB + 1;
   localparam int NV  = ND + 5;

   logic [NV-1:0] vld_ff;

   lci_pkg::side_type  g0_side_ff, g1_side_ff, g2_side_ff;
   lci_pkg::side_type  dv_side_ff [0:QB];
   lci_pkg::side_type  h0_side_ff, h1_side_ff;

   logic signed [TW-1:0] t_ff   [0:1];
   logic signed [TW-1:0] t_in   [0:1];
   logic [MW-1:0]        mag_ff [0:1];
   logic                 neg1_ff [0:1];
   logic [PPW-1:0]       pp0_ff [0:1];
   logic [PPW-1:0]       pp1_ff [0:1];
   logic                 neg2_ff [0:1];
   logic [NB-1:0]        num_ff [0:QB][0:1];
   logic [LW-1:0]        rem_ff [0:QB][0:1];
   logic [QB-1:0]        quo_ff [0:QB][0:1];
   logic                 negd_ff [0:QB][0:1];
   logic signed [QSW-1:0] qs_ff [0:1];
   logic signed [W-1:0]   x_ff  [0:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NV-2:0], in_valid};
      end
   end

   assign t_in[0] = TW'(0) - TW'(in_side.p) - $signed({{(TW-SB){1'b0}}, in_s});
   assign t_in[1] = TW'(0) - TW'(in_side.p) + $signed({{(TW-SB){1'b0}}, in_s});

   always_ff @(posedge clock) begin
      if (adv) begin
         g0_side_ff    <= in_side;
         g1_side_ff    <= g0_side_ff;
         g2_side_ff    <= g1_side_ff;
         dv_side_ff[0] <= g2_side_ff;
         h0_side_ff    <= dv_side_ff[QB];
         h1_side_ff    <= h0_side_ff;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_side_ff[k+1] <= dv_side_ff[k];
         end
      end
   end

   for (genvar n = 0; n < 2; n++) begin : g_lane
      logic [TW-1:0]  t_abs;
      logic [NB-1:0]  num_in;
      logic [QSW-1:0] q_ext;
      logic [QSW-1:0] qs_in;
      logic signed [SUW-1:0] sum;
      logic           fits;

      assign t_abs  = t_ff[n][TW-1] ? (TW'(0) - t_ff[n]) : t_ff[n];
      assign num_in = NB'(pp0_ff[n]) + (NB'(pp1_ff[n]) << HM);
      assign q_ext  = QSW'(quo_ff[QB][n]);
      assign qs_in  = negd_ff[QB][n]
                    ? (QSW'(0) - q_ext - QSW'(rem_ff[QB][n] != '0)) : q_ext;
      assign sum    = SUW'(h0_side_ff.x1) + SUW'(qs_ff[n]);
      assign fits   = (sum[SUW-1:W-1] == {(SUW-W+1){sum[SUW-1]}});

      always_ff @(posedge clock) begin
         if (adv) begin
            t_ff[n]       <= t_in[n];
            mag_ff[n]     <= t_abs[MW-1:0];
            neg1_ff[n]    <= g0_side_ff.dx_neg ^ t_ff[n][TW-1];
            pp0_ff[n]     <= g1_side_ff.dx_mag * mag_ff[n][HM-1:0];
            pp1_ff[n]     <= g1_side_ff.dx_mag * mag_ff[n][MW-1:HM];
            neg2_ff[n]    <= neg1_ff[n];
            num_ff[0][n]  <= num_in;
            rem_ff[0][n]  <= LW'(num_in[NB-1:QB]);
            quo_ff[0][n]  <= '0;
            negd_ff[0][n] <= neg2_ff[n];
            qs_ff[n]      <= qs_in;
            if (fits) begin
               x_ff[n] <= sum[W-1:0];
            end else if (sum[SUW-1]) begin
               x_ff[n] <= {1'b1, {(W-1){1'b0}}};
            end else begin
               x_ff[n] <= {1'b0, {(W-1){1'b1}}};
            end
         end
      end

      for (genvar k = 0; k < QB; k++) begin : g_step
         localparam int B = QB - 1 - k;
         logic [LW:0] cand;
         logic        ge;

         assign cand = {rem_ff[k][n], num_ff[k][n][B]};
         assign ge   = (cand >= {1'b0, dv_side_ff[k].l2});

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k+1][n]  <= ge ? LW'(cand - {1'b0, dv_side_ff[k].l2}) : cand[LW-1:0];
               quo_ff[k+1][n]  <= {quo_ff[k][n][QB-2:0], ge};
               num_ff[k+1][n]  <= num_ff[k][n];
               negd_ff[k+1][n] <= negd_ff[k][n];
            end
         end
      end
   end

   assign out_valid = vld_ff[NV-1];
   assign out_side  = h1_side_ff;
   assign out_xa    = x_ff[0];
   assign out_xb    = x_ff[1];

endmodule
